### rtl/cc2us_pkg.sv
// Shared types and constants for the cycle count to microseconds unit.
// Used by the configuration registers, the divider and the top level.
package cc2us_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned CPU_W     = 10;
  localparam int unsigned DIVIDEND_W = SAMPLE_W + 1;

  // One quotient bit per divider step
  localparam int unsigned DIV_STEPS = DIVIDEND_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // APB register map
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    REG_CPU     = 1'b0,
    REG_ENABLED = 1'b1
  } reg_idx_t;

  // Function codes of a request
  typedef enum logic {
    FUNC_RESTART = 1'b0,
    FUNC_RESOLVE = 1'b1
  } func_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic             enabled;
  } cfg_t;

  // Divider start request
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [CPU_W-1:0]      divisor;
  } div_req_t;

  // Divider status and results
  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
    logic [CPU_W-1:0]      rem;
  } div_status_t;

endpackage

### rtl/cc2us_cfg.sv
// APB configuration registers: cycles per microsecond and counter enable.
// Depends on cc2us_pkg for widths, register indexes and the cfg_t struct.
module cc2us_cfg
  import cc2us_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic             cpu;
  logic [CPU_W-1:0] cpu_reg;
  logic             enabled;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);
  assign cpu    = (idx == REG_CPU);

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_reg <= '0;
      enabled <= 1'b0;
    end else if (wr_en) begin
      if (cpu) begin
        cpu_reg <= pwdata[CPU_W-1:0];
      end else begin
        enabled <= pwdata[0];
      end
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    case (idx)
      REG_CPU:     prdata = DATA_W'(cpu_reg);
      REG_ENABLED: prdata = DATA_W'(enabled);
      default:     prdata = '0;
    endcase
  end

  assign cfg.cpu     = cpu_reg;
  assign cfg.enabled = enabled;

endmodule

### rtl/cc2us_div.sv
// Radix-2 restoring divider: 33-bit dividend by 10-bit divisor, one bit a cycle.
// Depends on cc2us_pkg for widths and the div_req_t / div_status_t structs.
module cc2us_div
  import cc2us_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output div_status_t status
);

  logic [DIVIDEND_W-1:0] quot;
  logic [CPU_W-1:0]      rem;
  logic [CPU_W-1:0]      divisor;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  busy;
  logic                  done;

  logic [CPU_W:0]        shifted;
  logic [CPU_W:0]        diff;
  logic                  q_bit;
  logic [CPU_W-1:0]      rem_next;

  // Shift in the next dividend bit and try one subtraction
  always_comb begin
    shifted  = {rem, quot[DIVIDEND_W-1]};
    diff     = shifted - {1'b0, divisor};
    q_bit    = (shifted >= {1'b0, divisor});
    rem_next = q_bit ? diff[CPU_W-1:0] : shifted[CPU_W-1:0];
  end

  // Sequencer: load on start, step until the count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot    <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quot <= {quot[DIVIDEND_W-2:0], q_bit};
      rem  <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.quot = quot;
  assign status.rem  = rem;

endmodule

### rtl/cycle_count_to_microseconds_unit.sv
// Top level of the cycle count to microseconds unit: sequencer, timing state,
// output register. Depends on cc2us_pkg, cc2us_cfg and cc2us_div.
//
// Each request carries a sample of a free-running 32-bit cycle counter. A
// restart request (func 0) takes its sample as the baseline and clears the
// elapsed time; it succeeds when counter_enabled is set and
// cycles_per_microsecond is nonzero. A resolve request (func 1) divides the
// wrapped cycle difference plus the kept remainder by cycles_per_microsecond,
// adds the quotient to the elapsed microseconds (wrapping) and returns it;
// without a prior good restart or with an unusable configuration it returns
// ok = 0, elapsed_us = 0. Every request gives exactly one result. A resolve
// reaches the output register after the 33 steps of the radix-2 divider, an
// update of the timing state and a load; restart and failed requests go
// straight to the finish state and are loaded from there; a stalled output
// register delays the load. in_stall is high from acceptance until the result
// is loaded into the output register, so no new request is taken meanwhile.
// Configuration is written through the APB port at byte addresses 0 and 4 by
// the user only while no request is in work; the block does not enforce it.
module cycle_count_to_microseconds_unit
  import cc2us_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // Request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [SAMPLE_W-1:0] cycle_sample,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] elapsed_us,
  output logic                ok
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIVIDE = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                state;
  state_t                state_next;

  cfg_t                  cfg;
  div_req_t              div_req;
  div_status_t           div_st;

  logic                  ready_flag;
  logic [SAMPLE_W-1:0]   last_sample;
  logic [CPU_W-1:0]      leftover_cycles;
  logic [SAMPLE_W-1:0]   elapsed_microseconds;

  logic [SAMPLE_W-1:0]   res_ts;
  logic                  res_ok;

  logic                  in_accept;
  logic                  usable;
  logic                  out_free;
  logic [SAMPLE_W-1:0]   delta;
  logic [SAMPLE_W-1:0]   elapsed_sum;

  cc2us_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cc2us_div u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .status (div_st)
  );

  assign in_stall    = (state != S_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign usable      = cfg.enabled && (cfg.cpu != '0);
  assign out_free    = !out_valid || !out_stall;
  assign delta       = cycle_sample - last_sample;
  assign elapsed_sum = elapsed_microseconds + div_st.quot[SAMPLE_W-1:0];

  // Start the divider on a usable resolve request after a good restart
  always_comb begin
    div_req.start    = in_accept && (func_t'(func) == FUNC_RESOLVE) && usable && ready_flag;
    div_req.dividend = {1'b0, delta} + DIVIDEND_W'(leftover_cycles);
    div_req.divisor  = cfg.cpu;
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (div_req.start) begin
          state_next = S_DIVIDE;
        end else if (in_accept) begin
          state_next = S_FINISH;
        end
      end
      S_DIVIDE: begin
        if (div_st.done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Timing state and the pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flag           <= 1'b0;
      last_sample          <= '0;
      leftover_cycles      <= '0;
      elapsed_microseconds <= '0;
      res_ts               <= '0;
      res_ok               <= 1'b0;
    end else if (in_accept) begin
      res_ts <= '0;
      res_ok <= 1'b0;
      case (func_t'(func))
        FUNC_RESTART: begin
          leftover_cycles      <= '0;
          elapsed_microseconds <= '0;
          ready_flag           <= usable;
          last_sample          <= usable ? cycle_sample : '0;
          res_ok               <= usable;
        end
        FUNC_RESOLVE: begin
          if (div_req.start) begin
            last_sample <= cycle_sample;
          end else begin
            ready_flag <= 1'b0;
          end
        end
        default: ready_flag <= 1'b0;
      endcase
    end else if (div_st.done) begin
      elapsed_microseconds <= elapsed_sum;
      leftover_cycles      <= div_st.rem;
      res_ts               <= elapsed_sum;
      res_ok               <= 1'b1;
    end
  end

  // Output register: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      elapsed_us <= res_ts;
      ok         <= res_ok;
    end
  end

  // A failed request never reports a timestamp
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (elapsed_us == '0))
    else $error("failed result carries a nonzero timestamp");

  // The divider finishes only while the sequencer waits for it
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIVIDE))
    else $error("divider done outside the divide state");

  // The divider is busy or signalling done whenever the sequencer is dividing
  a_busy_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> (div_st.busy || div_st.done))
    else $error("divide state without an active divider");

endmodule
